// ===== rtl/kplc_pkg.sv =====
// Shared types and constants for the keypad PIN lock controller.
package kplc_pkg;

    localparam int PIN_LENGTH_DEF = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WRONG   = 2'd0,
        CFG_CLOSE_COUNT = 2'd1,
        CFG_NEAR_DIST   = 2'd2
    } cfg_idx_t;

    localparam logic [3:0] MAX_WRONG_RST   = 4'd3;
    localparam logic [7:0] CLOSE_COUNT_RST = 8'd50;
    localparam logic [7:0] NEAR_DIST_RST   = 8'd100;

    localparam logic [7:0] KEY_ZERO = 8'd48;
    localparam logic [7:0] KEY_NINE = 8'd57;
    localparam logic [7:0] KEY_ONE  = 8'd49;
    localparam logic [7:0] KEY_TWO  = 8'd50;

    localparam logic [3:0] PIN_DIGIT_RST = 4'd1;
    localparam logic [3:0] WRONG_SAT     = 4'd15;
    localparam logic [7:0] SAMPLE_SAT    = 8'd255;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef enum logic [3:0] {
        ST_IGNORED    = 4'd0,
        ST_MODE       = 4'd1,
        ST_DIGIT      = 4'd2,
        ST_OPENED     = 4'd3,
        ST_WRONG      = 4'd4,
        ST_ALARM_ON   = 4'd5,
        ST_ALARM_BAD  = 4'd6,
        ST_ALARM_OFF  = 4'd7,
        ST_VERIFIED   = 4'd8,
        ST_PIN_CHANGE = 4'd9,
        ST_PRESENCE   = 4'd10,
        ST_COUNTING   = 4'd11
    } status_t;

    typedef struct packed {
        logic [3:0] max_wrong_tries;
        logic [7:0] close_samples;
        logic [7:0] near_distance;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] key_byte;
        logic [7:0] distance_sample;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic       lock_open;
        logic       buzzer_on;
        logic [2:0] digits_entered;
        logic [3:0] wrong_tries;
        logic [7:0] close_progress;
    } res_t;

endpackage

// ===== rtl/kplc_cfg.sv =====
// Configuration register file for the keypad PIN lock controller.
module kplc_cfg
    import kplc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [3:0] max_wrong_reg;
    logic [7:0] close_count_reg;
    logic [7:0] near_dist_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_wrong_reg   <= MAX_WRONG_RST;
            close_count_reg <= CLOSE_COUNT_RST;
            near_dist_reg   <= NEAR_DIST_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_WRONG:   max_wrong_reg   <= cfg_data[3:0];
                CFG_CLOSE_COUNT: close_count_reg <= cfg_data;
                CFG_NEAR_DIST:   near_dist_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.max_wrong_tries = max_wrong_reg;
    assign cfg.close_samples   = close_count_reg;
    assign cfg.near_distance   = near_dist_reg;

endmodule

// ===== rtl/kplc_core.sv =====
// Lock state machine: PIN entry, compare, change, alarm and close counting.
module kplc_core
    import kplc_pkg::*;
#(
    parameter int PIN_LENGTH = PIN_LENGTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step_en,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam int CNT_W = (PIN_LENGTH > 1) ? $clog2(PIN_LENGTH) : 1;
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(PIN_LENGTH - 1);

    typedef enum logic [2:0] {
        MODE_MENU,
        MODE_ENTRY,
        MODE_CHG_VERIFY,
        MODE_CHG_NEW,
        MODE_ALARM,
        MODE_OPEN
    } mode_t;

    mode_t            mode_reg,      mode_next;
    logic [CNT_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic [3:0]       wrong_cnt_reg, wrong_cnt_next;
    logic [7:0]       sample_cnt_reg, sample_cnt_next;

    logic [3:0] pin_reg   [PIN_LENGTH];
    logic [3:0] entry_reg [PIN_LENGTH];

    logic       is_digit;
    logic [3:0] digit;
    logic       last_digit;
    logic       match;
    logic [3:0] wrong_inc;
    logic [7:0] sample_inc;
    logic       wr_entry;
    logic       wr_pin;
    status_t    status;

    assign is_digit   = (item.key_byte >= KEY_ZERO) && (item.key_byte <= KEY_NINE);
    assign digit      = 4'(item.key_byte - KEY_ZERO);
    assign last_digit = (digit_cnt_reg == LAST_DIGIT);
    assign wrong_inc  = (wrong_cnt_reg < WRONG_SAT) ? wrong_cnt_reg + 4'd1 : wrong_cnt_reg;
    assign sample_inc = (sample_cnt_reg < SAMPLE_SAT) ? sample_cnt_reg + 8'd1 : sample_cnt_reg;

    // Compare against the buffer as it stands once the current digit is in.
    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < PIN_LENGTH; k++)
        begin
            if (digit_cnt_reg == CNT_W'(k))
            begin
                if (digit != pin_reg[k])
                    match = 1'b0;
            end
            else if (entry_reg[k] != pin_reg[k])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        digit_cnt_next  = digit_cnt_reg;
        wrong_cnt_next  = wrong_cnt_reg;
        sample_cnt_next = sample_cnt_reg;
        wr_entry        = 1'b0;
        wr_pin          = 1'b0;
        status          = ST_IGNORED;

        if (item.func)
        begin
            if (mode_reg == MODE_OPEN)
            begin
                if (item.distance_sample < cfg.near_distance)
                begin
                    sample_cnt_next = '0;
                    status          = ST_PRESENCE;
                end
                else
                begin
                    status = ST_COUNTING;
                    if (sample_inc >= cfg.close_samples)
                    begin
                        sample_cnt_next = '0;
                        mode_next       = MODE_MENU;
                    end
                    else
                    begin
                        sample_cnt_next = sample_inc;
                    end
                end
            end
        end
        else if (is_digit)
        begin
            unique case (mode_reg)
                MODE_MENU:
                begin
                    if (item.key_byte == KEY_ONE)
                    begin
                        mode_next      = MODE_ENTRY;
                        digit_cnt_next = '0;
                        status         = ST_MODE;
                    end
                    else if (item.key_byte == KEY_TWO)
                    begin
                        mode_next      = MODE_CHG_VERIFY;
                        digit_cnt_next = '0;
                        status         = ST_MODE;
                    end
                end
                MODE_CHG_NEW:
                begin
                    wr_pin = 1'b1;
                    if (last_digit)
                    begin
                        digit_cnt_next = '0;
                        mode_next      = MODE_MENU;
                        status         = ST_PIN_CHANGE;
                    end
                    else
                    begin
                        digit_cnt_next = digit_cnt_reg + 1'b1;
                        status         = ST_DIGIT;
                    end
                end
                MODE_ENTRY, MODE_CHG_VERIFY, MODE_ALARM:
                begin
                    wr_entry = 1'b1;
                    if (!last_digit)
                    begin
                        digit_cnt_next = digit_cnt_reg + 1'b1;
                        status         = ST_DIGIT;
                    end
                    else
                    begin
                        digit_cnt_next = '0;
                        priority if (mode_reg == MODE_ALARM)
                        begin
                            if (match)
                            begin
                                wrong_cnt_next = '0;
                                mode_next      = MODE_MENU;
                                status         = ST_ALARM_OFF;
                            end
                            else
                            begin
                                status = ST_ALARM_BAD;
                            end
                        end
                        else if (match && mode_reg == MODE_CHG_VERIFY)
                        begin
                            mode_next = MODE_CHG_NEW;
                            status    = ST_VERIFIED;
                        end
                        else if (match)
                        begin
                            wrong_cnt_next  = '0;
                            sample_cnt_next = '0;
                            mode_next       = MODE_OPEN;
                            status          = ST_OPENED;
                        end
                        else
                        begin
                            wrong_cnt_next = wrong_inc;
                            if (wrong_inc >= cfg.max_wrong_tries)
                            begin
                                mode_next = MODE_ALARM;
                                status    = ST_ALARM_ON;
                            end
                            else
                            begin
                                mode_next = MODE_MENU;
                                status    = ST_WRONG;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_MENU;
            digit_cnt_reg  <= '0;
            wrong_cnt_reg  <= '0;
            sample_cnt_reg <= '0;
            for (int k = 0; k < PIN_LENGTH; k++)
                pin_reg[k] <= PIN_DIGIT_RST;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            digit_cnt_reg  <= digit_cnt_next;
            wrong_cnt_reg  <= wrong_cnt_next;
            sample_cnt_reg <= sample_cnt_next;
            if (wr_pin)
                pin_reg[digit_cnt_reg] <= digit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && wr_entry)
            entry_reg[digit_cnt_reg] <= digit;
    end

    assign res.status         = status;
    assign res.lock_open      = (mode_next == MODE_OPEN);
    assign res.buzzer_on      = (mode_next == MODE_ALARM);
    assign res.digits_entered = 3'(digit_cnt_next);
    assign res.wrong_tries    = wrong_cnt_next;
    assign res.close_progress = sample_cnt_next;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg <= LAST_DIGIT)
        else $error("digit count past PIN length");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(mode_reg) && $stable(wrong_cnt_reg) && $stable(sample_cnt_reg))
        else $error("state moved without a beat");

    a_nondigit: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !item.func && !is_digit |=> $stable(mode_reg) && $stable(digit_cnt_reg))
        else $error("non-digit key changed state");

    a_sample_open: assert property (@(posedge clk) disable iff (!rst_n)
        sample_cnt_reg != '0 |-> mode_reg == MODE_OPEN)
        else $error("close count running while not open");

endmodule

// ===== rtl/keypad_pin_lock_controller.sv =====
// Path: input register, then result register; one item per cycle while m_tready keeps up.
// The state update is a single pass from the input register.
// The input register drains whenever the result register is empty or being taken.
// Reset: asynchronous, active low; menu mode, PIN all ones, counters zero, lock closed,
// alarm off, configuration back to 3 / 50 / 100.
module keypad_pin_lock_controller
    import kplc_pkg::*;
#(
    parameter int PIN_LENGTH = PIN_LENGTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // key_byte[7:0], distance_sample[15:8]
    input  logic                  s_tuser,  // func[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // status[3:0], lock_open[4], buzzer_on[5],
                                            // digits_entered[8:6], wrong_tries[12:9],
                                            // close_progress[20:13], zero[23:21]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  out_res_reg;
    logic  out_valid_reg;
    logic  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kplc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kplc_core #(
        .PIN_LENGTH (PIN_LENGTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: the input loads on accept, the result on advance; both hold otherwise.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.func            <= s_tuser;
            in_item_reg.key_byte        <= s_tdata[7:0];
            in_item_reg.distance_sample <= s_tdata[15:8];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.close_progress,
                       out_res_reg.wrong_tries,
                       out_res_reg.digits_entered,
                       out_res_reg.buzzer_on,
                       out_res_reg.lock_open,
                       out_res_reg.status};

endmodule

// ===== tb/sv/lock_response_board_pkg.sv =====
// Scoreboard class that predicts and checks the lock controller's result beats.
package lock_response_board_pkg;

    import kplc_pkg::*;

    typedef enum logic [2:0] {
        LOCK_MENU,
        LOCK_ENTRY,
        LOCK_CHG_VERIFY,
        LOCK_CHG_NEW,
        LOCK_ALARM,
        LOCK_OPEN
    } lock_mode_t;

    localparam int REPORT_MAX = 10;
    localparam int PIN_IDX_W  = (PIN_LENGTH_DEF > 1) ? $clog2(PIN_LENGTH_DEF) : 1;

    class lock_response_board;

        bit [3:0]                          max_wrong;
        bit [7:0]                          close_limit;
        bit [7:0]                          near_limit;

        lock_mode_t                        mode;
        bit [PIN_LENGTH_DEF-1:0][3:0]      pin;
        bit [PIN_LENGTH_DEF-1:0][3:0]      entry;
        bit [2:0]                          digits;
        bit [3:0]                          wrong;
        bit [7:0]                          far_count;
        bit                                lock_open;
        bit                                alarm;

        res_t                              expected_responses[$];
        int unsigned                       errors;

        function new();
            max_wrong   = MAX_WRONG_RST;
            close_limit = CLOSE_COUNT_RST;
            near_limit  = NEAR_DIST_RST;
            mode        = LOCK_MENU;
            pin         = {PIN_LENGTH_DEF{PIN_DIGIT_RST}};
            entry       = '0;
            digits      = '0;
            wrong       = '0;
            far_count   = '0;
            lock_open   = 1'b0;
            alarm       = 1'b0;
            errors      = 0;
        endfunction

        function void set_register(cfg_idx_t idx, bit [7:0] value);
            case (idx)
                CFG_MAX_WRONG:   max_wrong   = value[3:0];
                CFG_CLOSE_COUNT: close_limit = value;
                CFG_NEAR_DIST:   near_limit  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function status_t press_key(bit [7:0] key);
            bit [3:0] d;
            bit       ok;
            if (key < KEY_ZERO || key > KEY_NINE)
                return ST_IGNORED;
            d = 4'(key - KEY_ZERO);
            case (mode)
                LOCK_MENU:
                begin
                    if (key == KEY_ONE)
                    begin
                        mode   = LOCK_ENTRY;
                        digits = '0;
                        return ST_MODE;
                    end
                    if (key == KEY_TWO)
                    begin
                        mode   = LOCK_CHG_VERIFY;
                        digits = '0;
                        return ST_MODE;
                    end
                    return ST_IGNORED;
                end
                LOCK_CHG_NEW:
                begin
                    pin[PIN_IDX_W'(digits)] = d;
                    digits++;
                    if (digits >= PIN_LENGTH_DEF)
                    begin
                        digits = '0;
                        mode   = LOCK_MENU;
                        return ST_PIN_CHANGE;
                    end
                    return ST_DIGIT;
                end
                LOCK_ENTRY, LOCK_CHG_VERIFY, LOCK_ALARM:
                begin
                    entry[PIN_IDX_W'(digits)] = d;
                    digits++;
                    if (digits < PIN_LENGTH_DEF)
                        return ST_DIGIT;
                    digits = '0;
                    ok = (entry == pin);
                    if (mode == LOCK_ALARM)
                    begin
                        // only a correct PIN clears the alarm; wrong tries no longer count
                        if (!ok)
                            return ST_ALARM_BAD;
                        alarm = 1'b0;
                        wrong = '0;
                        mode  = LOCK_MENU;
                        return ST_ALARM_OFF;
                    end
                    if (ok)
                    begin
                        if (mode == LOCK_CHG_VERIFY)
                        begin
                            mode = LOCK_CHG_NEW;
                            return ST_VERIFIED;
                        end
                        lock_open = 1'b1;
                        wrong     = '0;
                        far_count = '0;
                        mode      = LOCK_OPEN;
                        return ST_OPENED;
                    end
                    if (wrong < WRONG_SAT)
                        wrong++;
                    if (wrong >= max_wrong)
                    begin
                        alarm = 1'b1;
                        mode  = LOCK_ALARM;
                        return ST_ALARM_ON;
                    end
                    mode = LOCK_MENU;
                    return ST_WRONG;
                end
                default: return ST_IGNORED;
            endcase
        endfunction

        function status_t take_sample(bit [7:0] distance);
            if (mode != LOCK_OPEN)
                return ST_IGNORED;
            if (distance < near_limit)
            begin
                far_count = '0;
                return ST_PRESENCE;
            end
            if (far_count < SAMPLE_SAT)
                far_count++;
            if (far_count >= close_limit)
            begin
                lock_open = 1'b0;
                far_count = '0;
                mode      = LOCK_MENU;
            end
            return ST_COUNTING;
        endfunction

        function void note_event(bit func, bit [7:0] key, bit [7:0] distance);
            res_t want;
            want.status         = func ? take_sample(distance) : press_key(key);
            want.lock_open      = lock_open;
            want.buzzer_on      = alarm;
            want.digits_entered = digits;
            want.wrong_tries    = wrong;
            want.close_progress = far_count;
            expected_responses.push_back(want);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] beat);
            res_t got;
            res_t want;
            got.status         = status_t'(beat[3:0]);
            got.lock_open      = beat[4];
            got.buzzer_on      = beat[5];
            got.digits_entered = beat[8:6];
            got.wrong_tries    = beat[12:9];
            got.close_progress = beat[20:13];
            if (expected_responses.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t unexpected response:", $time,
                             " st=%0d open=%0b buzz=%0b", got.status, got.lock_open,
                             got.buzzer_on,
                             " dig=%0d wrong=%0d far=%0d", got.digits_entered,
                             got.wrong_tries, got.close_progress);
                return;
            end
            want = expected_responses.pop_front();
            if (got.status !== want.status || got.lock_open !== want.lock_open ||
                got.buzzer_on !== want.buzzer_on ||
                got.digits_entered !== want.digits_entered ||
                got.wrong_tries !== want.wrong_tries ||
                got.close_progress !== want.close_progress)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t response mismatch:", $time,
                             " exp st=%0d open=%0b buzz=%0b", want.status, want.lock_open,
                             want.buzzer_on,
                             " dig=%0d wrong=%0d far=%0d", want.digits_entered,
                             want.wrong_tries, want.close_progress,
                             " | got st=%0d open=%0b buzz=%0b", got.status, got.lock_open,
                             got.buzzer_on,
                             " dig=%0d wrong=%0d far=%0d", got.digits_entered,
                             got.wrong_tries, got.close_progress);
            end
        endfunction

        function void close_out();
            if (expected_responses.size() != 0)
            begin
                errors += expected_responses.size();
                if (errors <= REPORT_MAX)
                    $display("%0d responses never arrived", expected_responses.size());
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/keypad_pin_lock_controller_tb.sv =====
// Top-level testbench for the keypad PIN lock controller.
module keypad_pin_lock_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kplc_pkg::*;
    import lock_response_board_pkg::*;

    localparam int IDLE_MAX       = 14;
    localparam int HOLD_CYCLES    = 240;
    localparam int HOLD_AFTER     = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 146;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lock_response_board    board;
    int unsigned           results_seen;
    int unsigned           quiet_cycles;
    bit                    quiet_in;

    keypad_pin_lock_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Valid stays high across back-to-back beats; drop it only for a drawn gap.
    task automatic offer_event(input bit func, input bit [7:0] key, input bit [7:0] distance);
        int gap;
        if ($urandom_range(0, 39) == 0)
            quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {distance, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_event(func, key, distance);
    endtask

    task automatic offer_key(input bit [7:0] key);
        offer_event(1'b0, key, 8'($urandom));
    endtask

    task automatic offer_sample(input bit [7:0] distance);
        offer_event(1'b1, 8'($urandom), distance);
    endtask

    task automatic load_settings(input bit [3:0] max_wrong, input bit [7:0] close_limit,
                                 input bit [7:0] near_limit);
        bit [7:0] values[3];
        values[0] = {4'd0, max_wrong};
        values[1] = close_limit;
        values[2] = near_limit;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= values[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.set_register(cfg_idx_t'(i), values[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Steer the next event from the predicted state so entries get completed.
    task automatic offer_random(input int aim);
        bit       func;
        bit [7:0] key;
        bit [7:0] distance;
        bit [3:0] digit;
        int       pick;
        int       near_odds;
        func     = 1'b0;
        key      = 8'($urandom);
        distance = 8'($urandom);
        if ($urandom_range(0, 99) < 8)
            func = 1'($urandom_range(0, 1));
        else
        begin
            case (board.mode)
                LOCK_MENU:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        key = KEY_ONE;
                    else if (pick < 9)
                        key = KEY_TWO;
                    else
                        key = KEY_ZERO + 8'($urandom_range(0, 9));
                end
                LOCK_OPEN:
                begin
                    func      = 1'b1;
                    near_odds = (board.close_limit > 16) ? 150 : 5;
                    if (board.near_limit != 0 && $urandom_range(1, near_odds) == 1)
                        distance = 8'($urandom_range(0, board.near_limit - 1));
                    else
                        distance = 8'($urandom_range(board.near_limit, 255));
                end
                LOCK_CHG_NEW:
                    key = KEY_ZERO + 8'($urandom_range(0, 9));
                default:
                begin
                    digit = ($urandom_range(0, 99) < aim)
                            ? board.pin[PIN_IDX_W'(board.digits)]
                            : 4'($urandom_range(0, 9));
                    key   = KEY_ZERO + 8'(digit);
                end
            endcase
        end
        offer_event(func, key, distance);
    endtask

    initial
    begin : stimulus
        int aim;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // non-digits, sample while closed, idle menu digit
        offer_key(8'h00);
        offer_key(8'hFF);
        offer_key(KEY_NINE + 8'd1);
        offer_sample(8'h00);
        offer_key(KEY_ZERO + 8'd5);
        // change PIN from the reset value to 9090
        offer_key(KEY_TWO);
        repeat (PIN_LENGTH_DEF) offer_key(KEY_ONE);
        offer_key(KEY_NINE);
        offer_key(KEY_ZERO);
        offer_key(KEY_NINE);
        offer_key(KEY_ZERO);
        // old PIN is now wrong, new one opens
        offer_key(KEY_ONE);
        repeat (PIN_LENGTH_DEF) offer_key(KEY_ONE);
        offer_key(KEY_ONE);
        offer_key(KEY_NINE);
        offer_key(KEY_ZERO);
        offer_key(KEY_NINE);
        offer_key(KEY_ZERO);
        // key while open, presence, far sample
        offer_key(KEY_ONE);
        offer_sample(8'h00);
        offer_sample(8'hFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            case (phase)
                0: aim = 85;
                1:
                begin
                    load_settings(4'd1, 8'd1, 8'd0);
                    aim = 60;
                end
                2:
                begin
                    load_settings(4'd15, 8'd4, 8'd255);
                    aim = 40;
                end
                3:
                begin
                    load_settings(4'd2, 8'd255, 8'd0);
                    aim = 90;
                end
                5:
                begin
                    load_settings(4'd15, 8'd1, 8'd128);
                    aim = 50;
                end
                default:
                begin
                    load_settings(4'($urandom_range(1, 15)),
                                  ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 60))
                                                              : 8'($urandom_range(1, 8)),
                                  8'($urandom));
                    aim = $urandom_range(50, 95);
                end
            endcase
            repeat (PHASE_ITEMS) offer_random(aim);
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        board.close_out();
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : drain
        int stall;
        bit quiet_out;
        bit held_off;
        quiet_out = 1'b0;
        held_off  = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // hold off once for a long stretch so the block backs up into its input
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                stall    = HOLD_CYCLES;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    quiet_out = !quiet_out;
                stall = quiet_out ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            board.check_result(m_tdata);
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ===== keypad_pin_lock_controller.f =====
rtl/kplc_pkg.sv
rtl/kplc_cfg.sv
rtl/kplc_core.sv
rtl/keypad_pin_lock_controller.sv
tb/sv/lock_response_board_pkg.sv
tb/sv/keypad_pin_lock_controller_tb.sv
